// ----- hw/rtl/multi_stream_audio_frame_mixer_defines.svh -----
// Assertion macros for the multi-stream audio frame mixer.
// No dependencies; included by the mixer top, the module that carries the assertions.
`ifndef MULTI_STREAM_AUDIO_FRAME_MIXER_DEFINES_SVH
`define MULTI_STREAM_AUDIO_FRAME_MIXER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define MSAFM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSAFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/msafm_pkg.sv -----
// Shared types and constants of the multi-stream audio frame mixer.
// No dependencies.
package msafm_pkg;

    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_FIFO_DEPTH = 2048;
    localparam int DEF_FRAME_LEN  = 320;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int FILL_W   = 12;
    // |sample * gain| >> 12 fits in this many bits
    localparam int MAG_W    = 20;
    localparam int DIV_BITS = 4;

    localparam logic [FILL_W-1:0] RST_MIN_FILL = 12'd320;
    localparam logic [15:0]       RST_GAIN     = 16'd4096;
    localparam logic [15:0]       RST_UNSCALED = 16'd9900;
    localparam logic [15:0]       UNITY_GAIN   = 16'd4096;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_PULL   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_PUSHED   = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_NO_FRAME = 2'd2,
        ST_MIXED    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_MIN_FILL = 2'd0,
        REG_GAIN     = 2'd1,
        REG_UNSCALED = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]                 command;
        logic [15:0]                stream_id;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic                       last_in_frame;
    } t_out_item;

endpackage

// ----- hw/rtl/msafm_store.sv -----
// Sample store: one FIFO region per stream slot, one write and one read port.
// Depends on msafm_pkg.
module msafm_store
    import msafm_pkg::*;
#(
    parameter int ENTRIES = DEF_CHANNELS * DEF_FIFO_DEPTH,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic signed [SAMPLE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic signed [SAMPLE_W-1:0] o_rdata
);

    logic signed [SAMPLE_W-1:0] r_mem [ENTRIES];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/msafm_div.sv -----
// Radix-16 restoring divider: magnitude by a small stream count, signed result.
// Depends on msafm_pkg.
module msafm_div
    import msafm_pkg::*;
#(
    parameter int NW = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [MAG_W-1:0]           i_num,
    input  logic                       i_neg,
    input  logic [NW-1:0]              i_den,
    output logic                       o_done,
    output logic signed [SAMPLE_W-1:0] o_quot
);

    localparam int STEPS = (MAG_W + DIV_BITS - 1) / DIV_BITS;
    localparam int KW    = $clog2(STEPS + 1);

    logic [KW-1:0]    r_cnt, n_cnt;
    logic [MAG_W-1:0] r_q, n_q;
    logic [NW-1:0]    r_rem, n_rem;
    logic [NW-1:0]    r_den;
    logic             r_neg;
    logic             r_done, n_done;

    always_comb begin
        logic [NW:0]      rem;
        logic [MAG_W-1:0] q;
        rem = {1'b0, r_rem};
        q   = r_q;
        for (int i = 0; i < DIV_BITS; i++) begin
            rem = {rem[NW-1:0], q[MAG_W-1]};
            q   = {q[MAG_W-2:0], 1'b0};
            if (rem >= {1'b0, r_den}) begin
                rem  = rem - {1'b0, r_den};
                q[0] = 1'b1;
            end
        end
        n_q    = q;
        n_rem  = rem[NW-1:0];
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (r_cnt != '0) begin
            n_cnt  = r_cnt - KW'(1);
            n_done = (r_cnt == KW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= KW'(STEPS);
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q[SAMPLE_W-1:0]) : $signed(r_q[SAMPLE_W-1:0]);

endmodule

// ----- hw/rtl/multi_stream_audio_frame_mixer.sv -----
// Multi-stream audio frame mixer: slot table, frame control and mix sequencer.
// Depends on msafm_pkg, msafm_store, msafm_div and the defines header.
//
// Usage: drive i_cmd and raise start while busy is low; that edge is the
// transfer. busy stays high until the result, which appears for one cycle
// on o_res with o_strobe high. The receiver cannot stall the block.
// Push (store a sample for a stream id) and clear are carried out in the
// execute state, which registers the strobe. A pull walks the stream slots
// one at a time through the sample store read port, one multiplier and the
// radix-16 divider (read, multiply, start, wait for each slot with a sample
// at this position), after a fill scan over all slots when a frame starts.
// Configuration writes (i_wr_en, i_wr_idx, i_wr_data) take effect at once;
// the user must make them only while idle; the block itself does not enforce it.
// Reset clears all slots and frame state; the sample store holds no reset
// and is only read where it was written.
`include "multi_stream_audio_frame_mixer_defines.svh"
module multi_stream_audio_frame_mixer
    import msafm_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
    parameter int FRAME_LEN  = DEF_FRAME_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_cmd,
    output logic             o_strobe,
    output t_out_item        o_res,
    input  logic             i_wr_en,
    input  logic [1:0]       i_wr_idx,
    input  logic [CFG_W-1:0] i_wr_data
);

    localparam int SW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW = $clog2(CHANNELS + 1);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int HW = $clog2(FIFO_DEPTH);
    localparam int PW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam int EW = HW + 2;
    localparam int XW = (CW > FILL_W) ? CW : FILL_W;
    localparam int ENTRIES = CHANNELS * FIFO_DEPTH;
    localparam int AW = $clog2(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SCAN, S_START, S_RD, S_MUL, S_DIV, S_WAIT, S_DONE
    } t_state;

    // configuration
    logic [FILL_W-1:0] r_min_fill;
    logic [15:0]       r_gain;
    logic [15:0]       r_unscaled;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic              r_valid [CHANNELS];
    logic              n_valid [CHANNELS];
    logic [15:0]       r_id    [CHANNELS];
    logic [15:0]       n_id    [CHANNELS];
    logic [HW-1:0]     r_head  [CHANNELS];
    logic [HW-1:0]     n_head  [CHANNELS];
    logic [CW-1:0]     r_count [CHANNELS];
    logic [CW-1:0]     n_count [CHANNELS];
    logic [CW-1:0]     r_snap  [CHANNELS];
    logic [CW-1:0]     n_snap  [CHANNELS];
    logic [PW-1:0]     r_pos, n_pos;
    logic              r_active, n_active;
    logic [NW-1:0]     r_nstr, n_nstr;
    logic [SW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_max, n_max;
    logic [15:0]       r_g, n_g;
    logic signed [SAMPLE_W+16:0] r_prod, n_prod;
    logic [SAMPLE_W-1:0] r_sum, n_sum;
    logic              r_strobe, n_strobe;
    t_out_item         r_res, n_res;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic signed [SAMPLE_W-1:0] mem_rdata;
    logic              div_start, div_done;
    logic [MAG_W-1:0]  div_num;
    logic signed [SAMPLE_W-1:0] div_quot;

    msafm_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_item.sample),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    msafm_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_neg   (r_prod < 0),
        .i_den   (r_nstr),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // magnitude of the product, then the Q4.12 scale by truncation
    always_comb begin
        logic [SAMPLE_W+16:0] mag;
        mag     = (r_prod < 0) ? $unsigned(-r_prod) : $unsigned(r_prod);
        div_num = mag[MAG_W+11:12];
    end

    always_comb begin
        logic             hit, found;
        logic [SW-1:0]    hslot, fslot, ps;
        logic [EW-1:0]    widx;
        logic [EW-1:0]    ridx;
        logic [CW-1:0]    k;
        logic [EW-1:0]    nh;
        logic [NW-1:0]    cnt;
        logic             last_slot;

        n_state  = r_state;
        n_valid  = r_valid;
        n_id     = r_id;
        n_head   = r_head;
        n_count  = r_count;
        n_snap   = r_snap;
        n_pos    = r_pos;
        n_active = r_active;
        n_nstr   = r_nstr;
        n_slot   = r_slot;
        n_max    = r_max;
        n_g      = r_g;
        n_prod   = r_prod;
        n_sum    = r_sum;
        n_strobe = 1'b0;
        n_res    = r_res;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_waddr = '0;
        mem_raddr = '0;
        div_start = 1'b0;
        k  = '0;
        nh = '0;

        // slot lookup for a push
        hit = 1'b0;  hslot = '0;
        found = 1'b0; fslot = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (r_valid[c] && r_id[c] == r_item.stream_id) begin
                hit = 1'b1;
                hslot = SW'(c);
            end
            if (!r_valid[c]) begin
                found = 1'b1;
                fslot = SW'(c);
            end
        end
        ps = hit ? hslot : fslot;

        widx = EW'(r_head[ps]) + EW'(r_count[ps]);
        if (!hit) begin
            widx = '0;
        end
        if (widx >= EW'(FIFO_DEPTH)) begin
            widx = widx - EW'(FIFO_DEPTH);
        end

        ridx = EW'(r_head[r_slot]) + EW'(r_pos);
        if (ridx >= EW'(FIFO_DEPTH)) begin
            ridx = ridx - EW'(FIFO_DEPTH);
        end

        last_slot = (r_slot == SW'(CHANNELS - 1));

        cnt = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_valid[c] && r_count[c] != '0) begin
                cnt = cnt + NW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.command)
                    CMD_PUSH: begin
                        n_state = S_IDLE;
                        n_strobe = 1'b1;
                        n_res = '{status: ST_DROPPED, mixed_sample: '0, last_in_frame: 1'b0};
                        if (hit || found) begin
                            if (!hit) begin
                                n_valid[ps] = 1'b1;
                                n_id[ps]    = r_item.stream_id;
                                n_head[ps]  = '0;
                                n_snap[ps]  = '0;
                            end
                            if (!hit || r_count[ps] < CW'(FIFO_DEPTH)) begin
                                n_count[ps] = hit ? r_count[ps] + CW'(1) : CW'(1);
                                mem_we      = 1'b1;
                                mem_waddr   = AW'(ps) * AW'(FIFO_DEPTH) + AW'(widx);
                                n_res.status = ST_PUSHED;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        n_state = S_IDLE;
                        n_strobe = 1'b1;
                        n_res = '{status: ST_NO_FRAME, mixed_sample: '0, last_in_frame: 1'b0};
                        for (int c = 0; c < CHANNELS; c++) begin
                            n_valid[c] = 1'b0;
                            n_head[c]  = '0;
                            n_count[c] = '0;
                            n_snap[c]  = '0;
                        end
                        n_pos = '0;
                        n_active = 1'b0;
                        n_nstr = '0;
                    end
                    CMD_PULL: begin
                        n_slot = '0;
                        n_sum  = '0;
                        n_max  = '0;
                        n_state = r_active ? S_RD : S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                        n_strobe = 1'b1;
                        n_res = '{status: ST_NO_FRAME, mixed_sample: '0, last_in_frame: 1'b0};
                    end
                endcase
            end
            S_SCAN: begin
                if (r_valid[r_slot] && r_count[r_slot] > r_max) begin
                    n_max = r_count[r_slot];
                end
                if (last_slot) begin
                    n_state = S_START;
                end else begin
                    n_slot = r_slot + SW'(1);
                end
            end
            S_START: begin
                if (XW'(r_max) < XW'(r_min_fill)) begin
                    n_state = S_IDLE;
                    n_strobe = 1'b1;
                    n_res = '{status: ST_NO_FRAME, mixed_sample: '0, last_in_frame: 1'b0};
                end else begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_snap[c] = (r_valid[c] && r_count[c] != '0) ? r_count[c] : '0;
                    end
                    n_nstr   = cnt;
                    n_pos    = '0;
                    n_active = 1'b1;
                    n_slot   = '0;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                if (CW'(r_pos) < r_snap[r_slot] && r_nstr != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_slot) * AW'(FIFO_DEPTH) + AW'(ridx);
                    n_g       = (r_id[r_slot] >= r_unscaled) ? UNITY_GAIN : r_gain;
                    n_state   = S_MUL;
                end else if (last_slot) begin
                    n_state = S_DONE;
                end else begin
                    n_slot = r_slot + SW'(1);
                end
            end
            S_MUL: begin
                n_prod  = mem_rdata * $signed({1'b0, r_g});
                n_state = S_DIV;
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_sum = r_sum + $unsigned(div_quot);
                    if (last_slot) begin
                        n_state = S_DONE;
                    end else begin
                        n_slot  = r_slot + SW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_DONE: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_res.status = ST_MIXED;
                n_res.mixed_sample = $signed(r_sum);
                n_res.last_in_frame = (r_pos == PW'(FRAME_LEN - 1));
                if (r_pos == PW'(FRAME_LEN - 1)) begin
                    // frame end: retire mixed samples, free emptied slots
                    for (int c = 0; c < CHANNELS; c++) begin
                        k = r_snap[c];
                        if (k > CW'(FRAME_LEN)) begin
                            k = CW'(FRAME_LEN);
                        end
                        if (k > r_count[c]) begin
                            k = r_count[c];
                        end
                        nh = EW'(r_head[c]) + EW'(k);
                        if (nh >= EW'(FIFO_DEPTH)) begin
                            nh = nh - EW'(FIFO_DEPTH);
                        end
                        n_head[c]  = nh[HW-1:0];
                        n_count[c] = r_count[c] - k;
                        n_snap[c]  = '0;
                        if (r_valid[c] && r_count[c] == k) begin
                            n_valid[c] = 1'b0;
                        end
                    end
                    n_active = 1'b0;
                    n_pos    = '0;
                    n_nstr   = '0;
                end else begin
                    n_pos = r_pos + PW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_strobe   <= 1'b0;
            r_res      <= '0;
            r_min_fill <= RST_MIN_FILL;
            r_gain     <= RST_GAIN;
            r_unscaled <= RST_UNSCALED;
            r_pos      <= '0;
            r_active   <= 1'b0;
            r_nstr     <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_valid[c] <= 1'b0;
                r_head[c]  <= '0;
                r_count[c] <= '0;
                r_snap[c]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_res    <= n_res;
            r_pos    <= n_pos;
            r_active <= n_active;
            r_nstr   <= n_nstr;
            r_valid  <= n_valid;
            r_head   <= n_head;
            r_count  <= n_count;
            r_snap   <= n_snap;
            if (i_wr_en) begin
                case (i_wr_idx)
                    REG_MIN_FILL: r_min_fill <= i_wr_data[FILL_W-1:0];
                    REG_GAIN:     r_gain     <= i_wr_data;
                    REG_UNSCALED: r_unscaled <= i_wr_data;
                    default:      ;
                endcase
            end
        end
        if (r_state == S_IDLE && start) begin
            r_item <= i_cmd;
        end
        r_id   <= n_id;
        r_slot <= n_slot;
        r_max  <= n_max;
        r_g    <= n_g;
        r_prod <= n_prod;
        r_sum  <= n_sum;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    `MSAFM_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !o_strobe, "accepted command did not raise busy")
    `MSAFM_ASSERT_SAME(a_strobe_idle, o_strobe, !busy, "result shown while still working")
    `MSAFM_ASSERT_SAME(a_quiet_fields, o_strobe && o_res.status != ST_MIXED, o_res.mixed_sample == '0 && !o_res.last_in_frame, "mix fields set on a non-mix result")
    `MSAFM_ASSERT_SAME(a_last_ends_frame, o_strobe && o_res.last_in_frame, !r_active, "frame still active after its last sample")

endmodule

// ----- tb/sv/msafm_checker.sv -----
// Scoreboard for the multi-stream audio frame mixer: mirrors the slot table,
// the per-stream sample FIFOs and the frame state, predicts every result and compares.
// Depends on msafm_pkg.
module msafm_checker
    import msafm_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
    parameter int FRAME_LEN  = DEF_FRAME_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_in_item         i_cmd,
    input  logic             o_strobe,
    input  t_out_item        o_res,
    input  logic             i_wr_en,
    input  logic [1:0]       i_wr_idx,
    input  logic [CFG_W-1:0] i_wr_data,
    output int               o_pending,
    output int               o_fail,
    output int               o_mixed,
    output int               o_frames,
    output int               o_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [FILL_W-1:0]    min_fill;
    logic [15:0]          vol_gain;
    logic [15:0]          unscaled_min;

    logic                 slot_used [CHANNELS];
    logic [15:0]          slot_id   [CHANNELS];
    logic signed [15:0]   sample_mem [CHANNELS][FIFO_DEPTH];
    int                   rd_ptr    [CHANNELS];
    int                   fill      [CHANNELS];
    int                   snap      [CHANNELS];
    int                   frame_pos;
    logic                 in_frame;
    int                   n_streams;

    t_out_item            expected_q [$];

    function automatic void flush_streams();
        for (int c = 0; c < CHANNELS; c++) begin
            slot_used[c] = 1'b0;
            rd_ptr[c]    = 0;
            fill[c]      = 0;
            snap[c]      = 0;
        end
        frame_pos = 0;
        in_frame  = 1'b0;
        n_streams = 0;
    endfunction

    function automatic logic [1:0] store_sample(logic [15:0] id, logic signed [15:0] s);
        int slot;
        slot = -1;
        for (int c = 0; c < CHANNELS; c++)
            if (slot == -1 && slot_used[c] && slot_id[c] == id) slot = c;
        if (slot < 0) begin
            for (int c = 0; c < CHANNELS; c++)
                if (slot == -1 && !slot_used[c]) slot = c;
            if (slot < 0) return ST_DROPPED;
            slot_used[slot] = 1'b1;
            slot_id[slot]   = id;
            rd_ptr[slot]    = 0;
            fill[slot]      = 0;
            snap[slot]      = 0;
        end
        if (fill[slot] >= FIFO_DEPTH) return ST_DROPPED;
        sample_mem[slot][(rd_ptr[slot] + fill[slot]) % FIFO_DEPTH] = s;
        fill[slot]++;
        return ST_PUSHED;
    endfunction

    function automatic logic open_frame();
        int maxc;
        maxc = 0;
        for (int c = 0; c < CHANNELS; c++)
            if (slot_used[c] && fill[c] > maxc) maxc = fill[c];
        if (maxc < int'(min_fill)) return 1'b0;
        n_streams = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (slot_used[c] && fill[c] > 0) begin
                snap[c] = fill[c];
                n_streams++;
            end else begin
                snap[c] = 0;
            end
        end
        frame_pos = 0;
        in_frame  = 1'b1;
        return 1'b1;
    endfunction

    function automatic void close_frame();
        int k;
        for (int c = 0; c < CHANNELS; c++) begin
            k = snap[c];
            if (k > FRAME_LEN) k = FRAME_LEN;
            if (k > fill[c]) k = fill[c];
            rd_ptr[c] = (rd_ptr[c] + k) % FIFO_DEPTH;
            fill[c]  -= k;
            snap[c]   = 0;
            if (slot_used[c] && fill[c] == 0) slot_used[c] = 1'b0;
        end
        in_frame  = 1'b0;
        frame_pos = 0;
        n_streams = 0;
    endfunction

    function automatic t_out_item mix_result(t_in_item it);
        t_out_item  r;
        logic [15:0] acc;
        longint     v, g, q;
        r = '0;
        r.status = ST_NO_FRAME;
        if (it.command == CMD_PUSH) begin
            r.status = store_sample(it.stream_id, it.sample);
        end else if (it.command == CMD_CLEAR) begin
            flush_streams();
        end else if (it.command == CMD_PULL) begin
            if (in_frame || open_frame()) begin
                acc = '0;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (frame_pos < snap[c] && n_streams > 0) begin
                        v = longint'(sample_mem[c][(rd_ptr[c] + frame_pos) % FIFO_DEPTH]);
                        g = (slot_id[c] >= unscaled_min) ? longint'(UNITY_GAIN)
                                                         : longint'(vol_gain);
                        q = (v * g) / (64'sd4096 * longint'(n_streams));
                        acc += q[15:0];
                    end
                end
                r.status       = ST_MIXED;
                r.mixed_sample = acc;
                if (frame_pos + 1 >= FRAME_LEN) begin
                    r.last_in_frame = 1'b1;
                    close_frame();
                end else begin
                    frame_pos++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            min_fill     <= RST_MIN_FILL;
            vol_gain     <= RST_GAIN;
            unscaled_min <= RST_UNSCALED;
            flush_streams();
            expected_q.delete();
            o_pending <= 0;
            o_fail    <= 0;
            o_mixed   <= 0;
            o_frames  <= 0;
            o_dropped <= 0;
        end else begin
            // results first: a new transfer may land on the strobe edge
            if (o_strobe) begin
                if (expected_q.size() == 0) begin
                    if (o_fail < 10)
                        $display("%0t: result with nothing expected: %p", $time, o_res);
                    o_fail <= o_fail + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.status != o_res.status
                            || want.mixed_sample != o_res.mixed_sample
                            || want.last_in_frame != o_res.last_in_frame) begin
                        if (o_fail < 10)
                            $display("%0t: mismatch exp st=%0d mix=%0d last=%0d got st=%0d mix=%0d last=%0d",
                                     $time, want.status, want.mixed_sample, want.last_in_frame,
                                     o_res.status, o_res.mixed_sample, o_res.last_in_frame);
                        o_fail <= o_fail + 1;
                    end
                    if (want.status == ST_MIXED) o_mixed <= o_mixed + 1;
                    if (want.last_in_frame) o_frames <= o_frames + 1;
                    if (want.status == ST_DROPPED) o_dropped <= o_dropped + 1;
                end
            end
            if (start && !busy) expected_q = {expected_q, mix_result(i_cmd)};
            if (i_wr_en) begin
                case (i_wr_idx)
                    REG_MIN_FILL: min_fill     <= i_wr_data[FILL_W-1:0];
                    REG_GAIN:     vol_gain     <= i_wr_data;
                    REG_UNSCALED: unscaled_min <= i_wr_data;
                    default: ;
                endcase
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/sv/multi_stream_audio_frame_mixer_tb.sv -----
// Top of the mixer testbench: clock, reset, command and register stimulus, verdict.
// Depends on msafm_pkg, multi_stream_audio_frame_mixer and msafm_checker.
module multi_stream_audio_frame_mixer_tb;
    import msafm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_item         i_cmd = '0;
    logic             o_strobe;
    t_out_item        o_res;
    logic             i_wr_en = 1'b0;
    logic [1:0]       i_wr_idx = '0;
    logic [CFG_W-1:0] i_wr_data = '0;

    int pending, fails, n_mixed, n_frames, n_dropped;
    int idle_pct = 0;
    int n_items = 0;
    int cycles = 0;
    logic [15:0] id_pool [9];

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    multi_stream_audio_frame_mixer u_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd,
        .o_strobe, .o_res, .i_wr_en, .i_wr_idx, .i_wr_data
    );

    msafm_checker u_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .o_strobe, .o_res,
        .i_wr_en, .i_wr_idx, .i_wr_data,
        .o_pending(pending), .o_fail(fails), .o_mixed(n_mixed),
        .o_frames(n_frames), .o_dropped(n_dropped)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic issue(logic [1:0] cmd, logic [15:0] id, logic [15:0] s, logic be);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= '{command: cmd, stream_id: id, sample: s, block_end: be};
        do @(posedge i_clk); while (busy);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        i_wr_en   <= 1'b1;
        i_wr_idx  <= idx;
        i_wr_data <= val;
        @(negedge i_clk);
        i_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] fill_min, logic [15:0] g, logic [15:0] unscaled);
        settle();
        write_reg(REG_MIN_FILL, fill_min);
        write_reg(REG_GAIN, g);
        write_reg(REG_UNSCALED, unscaled);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // one round: a burst of pushes over a pool of ids, then mostly pulls
    task automatic mix_round(int n_ids);
        int n_push, n_pull;
        n_push = $urandom_range(1, 30);
        n_pull = $urandom_range(10, 60);
        for (int k = 0; k < n_ids; k++)
            id_pool[k] = ($urandom_range(3) == 0) ? 16'(9898 + $urandom_range(4))
                                                  : 16'($urandom);
        for (int k = 0; k < n_push; k++)
            issue(CMD_PUSH, id_pool[$urandom_range(n_ids - 1)], rand_sample(),
                  1'($urandom));
        for (int k = 0; k < n_pull; k++) begin
            case ($urandom_range(99))
                0:       issue(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
                1:       issue(CMD_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom));
                2, 3, 4, 5, 6, 7, 8, 9:
                         issue(CMD_PUSH, id_pool[$urandom_range(n_ids - 1)], rand_sample(),
                               1'($urandom));
                default: issue(CMD_PULL, 16'($urandom), 16'($urandom), 1'($urandom));
            endcase
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: defaults, no frame yet, unused code, slot table overflow
        issue(CMD_PULL, 16'd0, 16'd0, 1'b0);
        issue(CMD_UNUSED, 16'hffff, 16'hffff, 1'b1);
        issue(CMD_PUSH, 16'd0, 16'h8000, 1'b0);
        issue(CMD_PUSH, 16'hffff, 16'h7fff, 1'b1);
        for (int k = 1; k <= 7; k++)
            issue(CMD_PUSH, 16'(k), 16'(k * 1000), 1'b0);
        issue(CMD_PUSH, 16'd0, 16'hffff, 1'b0);
        issue(CMD_CLEAR, 16'd0, 16'd0, 1'b0);
        // zero threshold with nothing buffered gives a frame of zeros
        set_regs(16'd0, 16'd4096, 16'd9900);
        for (int k = 0; k < DEF_FRAME_LEN; k++) issue(CMD_PULL, 16'd0, 16'd0, 1'b0);
        // two uneven streams mixed at full gain and no bypass
        set_regs(16'd24, 16'hffff, 16'hffff);
        for (int k = 0; k < 24; k++)
            issue(CMD_PUSH, 16'd5, rand_sample(), 1'b0);
        issue(CMD_PUSH, 16'd6, 16'h8000, 1'b0);
        for (int k = 0; k < DEF_FRAME_LEN; k++) issue(CMD_PULL, 16'd0, 16'd0, 1'b0);
        issue(CMD_CLEAR, 16'd0, 16'd0, 1'b0);

        // random phases over register settings and sender idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin set_regs(16'd0, 16'd0, 16'd0); idle_pct = 0; end
                1: begin set_regs(16'd8, 16'd4096, 16'd9900); idle_pct = 85; end
                2: begin set_regs(16'd2048, 16'hffff, 16'hffff); idle_pct = 13; end
                default: begin
                    set_regs(16'($urandom_range(1, 64)), 16'($urandom),
                             16'($urandom));
                    idle_pct = 0;
                end
            endcase
            for (int r = 0; r < 2; r++) mix_round($urandom_range(1, 9));
            if (ph == 4) settle();   // hold off until every result is back
        end

        settle();
        repeat (100) @(negedge i_clk);
        $display("Ran %0d commands: %0d mixed samples in %0d complete frames, %0d pushes dropped.",
                 n_items, n_mixed, n_frames, n_dropped);
        if (fails == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
